FILE: hdl/segment_tree_range_aggregate_core_defines.svh
// Assertion helpers used by the checker module.
`ifndef SEGMENT_TREE_RANGE_AGGREGATE_CORE_DEFINES_SVH
`define SEGMENT_TREE_RANGE_AGGREGATE_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define STRA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define STRA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/stra_pkg.sv
package stra_pkg;

  // Node and leaf value width
  localparam int unsigned DATA_W = 64;

  // Default number of leaves
  localparam int unsigned LEAF_COUNT_DEF = 1024;

  // Leaf index field width and aggregate mode width
  localparam int unsigned IDX_W  = 10;
  localparam int unsigned MODE_W = 2;

  // Aggregate mode codes; the unused code behaves as sum
  localparam logic [MODE_W-1:0] MODE_SUM = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MIN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd2;

  // Request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // Identity element of each mode
  function automatic logic [DATA_W-1:0] identity(input logic [MODE_W-1:0] mode);
    logic [DATA_W-1:0] id;
    case (mode)
      MODE_MIN: id = {1'b0, {(DATA_W-1){1'b1}}};
      MODE_MAX: id = {1'b1, {(DATA_W-1){1'b0}}};
      default:  id = '0;
    endcase
    return id;
  endfunction

endpackage

FILE: hdl/segment_tree_range_aggregate_core.sv
// Segment tree over LEAF_COUNT signed 64-bit leaves, kept in one node RAM of
// 2*LEAF_COUNT entries (leaf i at node LEAF_COUNT+i) with a single combine unit
// (sum, min or max) under a small sequencer. A write item stores its leaf, then
// climbs one tree level per cycle: the sibling read issued on the previous
// cycle is combined with the running path value and written to the parent.
// A write gives no result. A query item walks the range bounds upward, reading
// at most two nodes per level through the single RAM read port, one node per
// cycle, then folds in the last read and loads the result into the output
// register, which waits while an earlier result is still held there. Only one
// item is in flight; s_axis_tready is high in idle, also while a result waits
// in the output register. After reset and after every aggregate_mode write, a
// clearing pass sets all 2*LEAF_COUNT nodes to the mode's identity; no item is
// accepted during it, but the config port is always ready. Write the mode only
// while the block is idle.
module segment_tree_range_aggregate_core #(
  parameter int unsigned LEAF_COUNT = stra_pkg::LEAF_COUNT_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // [9:0] leaf_index, [73:10] leaf_value, [83:74] range_lo, [93:84] range_hi
  input  logic [95:0]                   s_axis_tdata,
  // [0] req_type
  input  logic                          s_axis_tuser,
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [63:0] aggregate
  output logic [stra_pkg::DATA_W-1:0]   m_axis_tdata,
  // aggregate_mode register write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [stra_pkg::MODE_W-1:0]   cfg_data_i
);

  localparam int unsigned NODE_COUNT = 2 * LEAF_COUNT;
  localparam int unsigned AW         = $clog2(NODE_COUNT);
  localparam int unsigned NW         = $clog2(NODE_COUNT + 1);
  localparam int unsigned DW         = stra_pkg::DATA_W;
  localparam int unsigned IW         = stra_pkg::IDX_W;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_QUERY
  } state_e;

  // input fields
  logic [IW-1:0] leaf_index;
  logic [DW-1:0] leaf_value;
  logic [IW-1:0] range_lo;
  logic [IW-1:0] range_hi;

  assign leaf_index = s_axis_tdata[9:0];
  assign leaf_value = s_axis_tdata[73:10];
  assign range_lo   = s_axis_tdata[83:74];
  assign range_hi   = s_axis_tdata[93:84];

  state_e                      state_q, state_d;
  logic [stra_pkg::MODE_W-1:0] mode_q, mode_d;
  logic [AW-1:0]               clr_cnt_q, clr_cnt_d;
  logic [AW-1:0]               node_q, node_d;
  logic [DW-1:0]               cur_q, cur_d;
  logic [NW-1:0]               l_q, l_d;
  logic [NW-1:0]               r_q, r_d;
  logic [DW-1:0]               acc_q, acc_d;
  logic                        pend_q, pend_d;
  logic                        out_valid_q, out_valid_d;
  logic [DW-1:0]               out_data_q, out_data_d;

  // RAM and combine unit hookup
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;
  logic [DW-1:0] alu_a;
  logic [DW-1:0] alu_y;

  stra_ram #(
    .WIDTH (DW),
    .DEPTH (NODE_COUNT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign alu_a = (state_q == ST_WALK) ? cur_q : acc_q;

  stra_alu u_alu (
    .mode_i (mode_q),
    .a_i    (alu_a),
    .b_i    (ram_rdata),
    .y_o    (alu_y)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign cfg_ready_o   = 1'b1;

  // sequencer next state
  always_comb begin
    logic [31:0]   leaf_w;
    logic [31:0]   idx_w;
    logic [31:0]   lo_w;
    logic [31:0]   hi_w;
    logic [31:0]   hic_w;
    logic [AW-1:0] leaf_node;
    logic [AW-1:0] parent;
    logic [NW-1:0] ln;
    logic [NW-1:0] rn;

    leaf_w    = 32'(LEAF_COUNT);
    idx_w     = 32'(leaf_index);
    lo_w      = 32'(range_lo);
    hi_w      = 32'(range_hi);
    hic_w     = (hi_w >= leaf_w) ? (leaf_w - 32'd1) : hi_w;
    leaf_node = AW'(idx_w + leaf_w);
    parent    = node_q >> 1;
    ln        = l_q;
    rn        = r_q;

    state_d     = state_q;
    mode_d      = mode_q;
    clr_cnt_d   = clr_cnt_q;
    node_d      = node_q;
    cur_d       = cur_q;
    l_d         = l_q;
    r_d         = r_q;
    acc_d       = acc_q;
    pend_d      = 1'b0;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_raddr   = '0;

    // result taken downstream
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = stra_pkg::identity(mode_q);
        if (clr_cnt_q == AW'(NODE_COUNT - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + AW'(1);
        end
      end

      ST_IDLE: begin
        if (s_axis_tvalid) begin
          if (s_axis_tuser == stra_pkg::REQ_WRITE) begin
            state_d = ST_WALK;
            if (idx_w < leaf_w) begin
              // store leaf, fetch its sibling for the first level
              ram_we    = 1'b1;
              ram_waddr = leaf_node;
              ram_wdata = leaf_value;
              ram_raddr = leaf_node ^ AW'(1);
              node_d    = leaf_node;
              cur_d     = leaf_value;
            end else begin
              // out of range: nothing to climb
              node_d = AW'(1);
            end
          end else begin
            state_d = ST_QUERY;
            acc_d   = stra_pkg::identity(mode_q);
            if (lo_w <= hic_w) begin
              l_d = NW'(lo_w + leaf_w);
              r_d = NW'(hic_w + leaf_w + 32'd1);
            end else begin
              l_d = '0;
              r_d = '0;
            end
          end
        end
      end

      ST_WALK: begin
        if (node_q == AW'(1)) begin
          state_d = ST_IDLE;
        end else begin
          // combine path value with sibling, write parent, fetch next sibling
          ram_we    = 1'b1;
          ram_waddr = parent;
          ram_wdata = alu_y;
          ram_raddr = parent ^ AW'(1);
          cur_d     = alu_y;
          node_d    = parent;
        end
      end

      ST_QUERY: begin
        if (pend_q) begin
          acc_d = alu_y;
        end
        if (l_q < r_q) begin
          // one node read per cycle from either bound
          if (l_q[0]) begin
            ram_raddr = l_q[AW-1:0];
            pend_d    = 1'b1;
            ln        = l_q + NW'(1);
          end else if (r_q[0]) begin
            rn        = r_q - NW'(1);
            ram_raddr = rn[AW-1:0];
            pend_d    = 1'b1;
          end
          // both bounds aligned: move up a level
          if (!ln[0] && !rn[0]) begin
            ln = ln >> 1;
            rn = rn >> 1;
          end
          l_d = ln;
          r_d = rn;
        end else if (!pend_q && (!out_valid_q || m_axis_tready)) begin
          out_valid_d = 1'b1;
          out_data_d  = acc_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // mode write restarts the clearing pass
    if (cfg_valid_i) begin
      mode_d    = cfg_data_i;
      clr_cnt_d = '0;
      state_d   = ST_CLEAR;
    end
  end

  // control state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      mode_q      <= stra_pkg::MODE_SUM;
      clr_cnt_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      clr_cnt_q   <= clr_cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      out_data_q  <= out_data_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    node_q <= node_d;
    cur_q  <= cur_d;
    l_q    <= l_d;
    r_q    <= r_d;
    acc_q  <= acc_d;
  end

endmodule

FILE: hdl/stra_ram.sv
// Simple dual-port RAM: one write port, one read port, registered read data.
module stra_ram #(
  parameter int unsigned WIDTH = stra_pkg::DATA_W,
  parameter int unsigned DEPTH = 2 * stra_pkg::LEAF_COUNT_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

FILE: hdl/stra_alu.sv
// Shared combine unit: wrapping add, or signed min / max select.
module stra_alu (
  input  logic [stra_pkg::MODE_W-1:0] mode_i,
  input  logic [stra_pkg::DATA_W-1:0] a_i,
  input  logic [stra_pkg::DATA_W-1:0] b_i,
  output logic [stra_pkg::DATA_W-1:0] y_o
);

  logic a_less;

  assign a_less = $signed(a_i) < $signed(b_i);

  always_comb begin
    case (mode_i)
      stra_pkg::MODE_MIN: y_o = a_less ? a_i : b_i;
      stra_pkg::MODE_MAX: y_o = a_less ? b_i : a_i;
      default:            y_o = a_i + b_i;
    endcase
  end

endmodule

FILE: hdl/stra_checker.sv
`include "segment_tree_range_aggregate_core_defines.svh"

// Port-level checks of the segment tree core.
module stra_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_tvalid_i,
  input logic                        s_tready_i,
  input logic                        m_tvalid_i,
  input logic                        m_tready_i,
  input logic [stra_pkg::DATA_W-1:0] m_tdata_i,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_i
);

  // an accepted item keeps the block busy in the next cycle
  `STRA_ASSERT_NEXT(a_busy_after_item, clk_i, rst_ni, s_tvalid_i && s_tready_i, !s_tready_i, "item accepted while busy")

  // a mode write starts the clearing pass
  `STRA_ASSERT_NEXT(a_clear_after_cfg, clk_i, rst_ni, cfg_valid_i && cfg_ready_i, !s_tready_i, "item accepted during clear")

  // a new result only comes out of a busy cycle
  `STRA_ASSERT_SAME(a_result_from_work, clk_i, rst_ni, $rose(m_tvalid_i), $past(!s_tready_i), "result without work")

  // a stalled result holds
  `STRA_ASSERT_NEXT(a_result_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i), "stalled result changed")

endmodule

bind segment_tree_range_aggregate_core stra_checker u_stra_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .s_tvalid_i  (s_axis_tvalid),
  .s_tready_i  (s_axis_tready),
  .m_tvalid_i  (m_axis_tvalid),
  .m_tready_i  (m_axis_tready),
  .m_tdata_i   (m_axis_tdata),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_i (cfg_ready_o)
);

FILE: tb/segment_tree_range_aggregate_core_test.sv
module segment_tree_range_aggregate_core_test;

  localparam int IW = stra_pkg::IDX_W;
  localparam int DW = stra_pkg::DATA_W;
  localparam int MW = stra_pkg::MODE_W;
  localparam int LEAVES = stra_pkg::LEAF_COUNT_DEF;
  // unused mode code, behaves as sum
  localparam logic [MW-1:0] MODE_SPARE = 2'd3;
  localparam logic [DW-1:0] VAL_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] VAL_MIN = {1'b1, {(DW-1){1'b0}}};
  // cycles a write may still be climbing the tree after the last result
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 500;

  typedef struct {
    logic          req;
    logic [IW-1:0] idx;
    logic [DW-1:0] val;
    logic [IW-1:0] lo;
    logic [IW-1:0] hi;
    int unsigned   gap;
  } tree_req_t;

  logic          clk_i;
  logic          rst_ni = 1'b0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [95:0]   s_axis_tdata = '0;
  logic          s_axis_tuser = 1'b0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [DW-1:0] m_axis_tdata;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [MW-1:0] cfg_data_i = '0;

  // predictor state
  logic [DW-1:0] leaf_shadow [LEAVES];
  logic [MW-1:0] mode_shadow = stra_pkg::MODE_SUM;

  tree_req_t     item_backlog [$];
  logic [DW-1:0] aggregate_expected [$];
  int            fail_count = 0;
  bit            in_fire = 1'b0;
  bit            hold_req = 1'b0;

  segment_tree_range_aggregate_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [DW-1:0] neutral_of(input logic [MW-1:0] m);
    if (m == stra_pkg::MODE_MIN) return VAL_MAX;
    if (m == stra_pkg::MODE_MAX) return VAL_MIN;
    return '0;
  endfunction

  function automatic logic [DW-1:0] merge(input logic [DW-1:0] a,
                                          input logic [DW-1:0] b);
    bit a_less;
    a_less = $signed(a) < $signed(b);
    if (mode_shadow == stra_pkg::MODE_MIN) return a_less ? a : b;
    if (mode_shadow == stra_pkg::MODE_MAX) return a_less ? b : a;
    return a + b;
  endfunction

  // fold over the leaves; same result as the tree walk since merge is
  // associative and commutative and untouched leaves hold the identity
  function automatic logic [DW-1:0] range_aggregate(input logic [IW-1:0] lo,
                                                    input logic [IW-1:0] hi);
    logic [DW-1:0] acc;
    int last;
    acc = neutral_of(mode_shadow);
    last = (int'(hi) >= LEAVES) ? LEAVES - 1 : int'(hi);
    for (int i = int'(lo); i <= last; i++) acc = merge(acc, leaf_shadow[i]);
    return acc;
  endfunction

  function automatic void clear_shadow(input logic [MW-1:0] m);
    mode_shadow = m;
    for (int i = 0; i < LEAVES; i++) leaf_shadow[i] = neutral_of(m);
  endfunction

  initial clear_shadow(stra_pkg::MODE_SUM);

  // ----------------------------------------------------------- random helpers

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DW-1:0] rand_value();
    int unsigned r;
    int s;
    longint w;
    r = $urandom_range(0, 99);
    if (r < 10) return VAL_MAX;
    if (r < 20) return VAL_MIN;
    if (r < 30) begin
      s = int'($urandom_range(0, 2));
      s = s - 1;
      w = longint'(s);
      return w;
    end
    if (r < 60) begin
      s = int'($urandom_range(0, 2000));
      s = s - 1000;
      w = longint'(s);
      return w;
    end
    return {$urandom, $urandom};
  endfunction

  function automatic logic [IW-1:0] rand_leaf();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return IW'($urandom_range(0, 15));
    if (r < 25) return '0;
    if (r < 30) return IW'(LEAVES - 1);
    return IW'($urandom_range(0, LEAVES - 1));
  endfunction

  // write item; query fields carry junk
  task automatic push_write(input logic [IW-1:0] idx, input logic [DW-1:0] val,
                            input int unsigned gap);
    tree_req_t t;
    t.req = stra_pkg::REQ_WRITE;
    t.idx = idx;
    t.val = val;
    t.lo  = IW'($urandom);
    t.hi  = IW'($urandom);
    t.gap = gap;
    item_backlog.push_back(t);
  endtask

  // query item; leaf fields carry junk
  task automatic push_query(input logic [IW-1:0] lo, input logic [IW-1:0] hi,
                            input int unsigned gap);
    tree_req_t t;
    t.req = stra_pkg::REQ_QUERY;
    t.idx = IW'($urandom);
    t.val = {$urandom, $urandom};
    t.lo  = lo;
    t.hi  = hi;
    t.gap = gap;
    item_backlog.push_back(t);
  endtask

  task automatic push_random(input int n);
    bit burst;
    int unsigned gap;
    int unsigned r;
    logic [IW-1:0] lo;
    int hi;
    burst = 1'b0;
    for (int i = 0; i < n; i++) begin
      // stretches with no gaps at all
      if (i % 40 == 0) burst = ($urandom_range(0, 2) == 0);
      gap = burst ? 0 : pick_gap();
      if ($urandom_range(0, 99) < 55) begin
        push_write(rand_leaf(), rand_value(), gap);
      end else begin
        r = $urandom_range(0, 99);
        lo = IW'($urandom_range(0, LEAVES - 1));
        if (r < 15) begin
          push_query('0, IW'(LEAVES - 1), gap);
        end else if (r < 30) begin
          push_query(lo, lo, gap);
        end else if (r < 40) begin
          push_query(lo | IW'(1), lo & ~IW'(1), gap);
        end else if (r < 70) begin
          hi = int'(lo) + int'($urandom_range(0, 15));
          if (hi > LEAVES - 1) hi = LEAVES - 1;
          push_query(lo, IW'(hi), gap);
        end else begin
          push_query(lo, IW'($urandom_range(0, LEAVES - 1)), gap);
        end
      end
    end
  endtask

  // sender pauses until the block is empty, then lets a write finish climbing
  task automatic wait_idle();
    @(posedge clk_i);
    while (item_backlog.size() != 0 || s_axis_tvalid || aggregate_expected.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_mode(input logic [MW-1:0] m);
    wait_idle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    clear_shadow(m);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    cfg_data_i  <= MW'($urandom);
  endtask

  // ----------------------------------------------------------------- driver

  tree_req_t cur_item;
  int unsigned gap_left = 0;

  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_fire)) begin
      in_fire = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (item_backlog.size() != 0) begin
        cur_item = item_backlog.pop_front();
        s_axis_tdata  <= {2'b00, cur_item.hi, cur_item.lo, cur_item.val, cur_item.idx};
        s_axis_tuser  <= cur_item.req;
        s_axis_tvalid <= 1'b1;
        gap_left = cur_item.gap;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // ----------------------------------------------------------------- receiver

  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned stretch_left = 0;
  bit sink_busy = 1'b0;

  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    // alternate stretches of random stalls and of steady ready
    if (stretch_left == 0) begin
      stretch_left = $urandom_range(20, 200);
      sink_busy = ($urandom_range(0, 1) == 1);
    end else begin
      stretch_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (sink_busy && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // ----------------------------------------------------------------- monitor

  always @(posedge clk_i) begin
    logic [DW-1:0] want;
    if (rst_ni && s_axis_tvalid && s_axis_tready === 1'b1) begin
      in_fire = 1'b1;
      if (s_axis_tuser == stra_pkg::REQ_QUERY) begin
        aggregate_expected.push_back(range_aggregate(s_axis_tdata[83:74], s_axis_tdata[93:84]));
      end else if (int'(s_axis_tdata[9:0]) < LEAVES) begin
        leaf_shadow[s_axis_tdata[9:0]] = s_axis_tdata[73:10];
      end
    end
    if (rst_ni && m_axis_tvalid === 1'b1 && m_axis_tready) begin
      if (aggregate_expected.size() == 0) begin
        $error("aggregate: expected none, actual %0d", $signed(m_axis_tdata));
        fail_count++;
      end else begin
        want = aggregate_expected.pop_front();
        if (m_axis_tdata !== want) begin
          $error("aggregate: expected %0d, actual %0d", $signed(want), $signed(m_axis_tdata));
          fail_count++;
        end
      end
    end
  end

  // ----------------------------------------------------------------- stimulus

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // sum mode out of reset: cleared tree, wrap at the extremes, empty range
    push_query('0, IW'(LEAVES - 1), pick_gap());
    push_write('0, VAL_MAX, pick_gap());
    push_write(IW'(LEAVES - 1), VAL_MAX, pick_gap());
    push_query('0, IW'(LEAVES - 1), pick_gap());
    push_write(IW'(LEAVES / 2), VAL_MIN, pick_gap());
    push_query('0, '0, pick_gap());
    push_query(IW'(LEAVES - 1), IW'(LEAVES - 1), pick_gap());
    push_query(IW'(5), IW'(3), pick_gap());
    push_query('0, IW'(LEAVES - 1), pick_gap());
    push_write(IW'(1), '1, pick_gap());
    push_query('0, IW'(1), pick_gap());
    push_random(65);
    wait_idle();
    push_random(65);

    // minimum mode, with a long receiver hold while items keep coming
    set_mode(stra_pkg::MODE_MIN);
    push_query('0, IW'(LEAVES - 1), pick_gap());
    push_write(IW'(7), VAL_MIN, pick_gap());
    push_write(IW'(8), VAL_MAX, pick_gap());
    push_query('0, IW'(LEAVES - 1), pick_gap());
    push_query(IW'(8), IW'(8), pick_gap());
    push_query(IW'(9), IW'(LEAVES - 1), pick_gap());
    push_random(130);
    // start the hold once the clearing pass is over
    @(posedge clk_i);
    while (s_axis_tready !== 1'b1) @(posedge clk_i);
    hold_req = 1'b1;

    // maximum mode
    set_mode(stra_pkg::MODE_MAX);
    push_write(IW'(LEAVES - 1), VAL_MIN, pick_gap());
    push_query(IW'(LEAVES - 1), IW'(LEAVES - 1), pick_gap());
    push_query('0, IW'(LEAVES - 2), pick_gap());
    push_write('0, VAL_MAX, pick_gap());
    push_query('0, IW'(LEAVES - 1), pick_gap());
    push_random(130);

    // unused code acts as sum
    set_mode(MODE_SPARE);
    push_random(130);

    set_mode(stra_pkg::MODE_SUM);
    push_random(130);

    set_mode(stra_pkg::MODE_MIN);
    push_random(140);

    wait_idle();
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // overall time limit
  initial begin
    #6000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
